// ----- rtl/core/sws_pkg.sv -----
// Shared command and status codes for the LIFO stack with search and remove.
package sws_pkg;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHOW   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ONE   = 5'b00010,
        S_FETCH = 5'b00100,
        S_WALK  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

endpackage

// ----- rtl/core/stack_with_search_remove.sv -----
// Top level of the bounded LIFO stack with show, count, remove and search.
//
//  channel | handshake        | payload
//  --------+------------------+-----------------------------
//  in      | i_vld / o_stall  | i_cmd, i_value
//  out     | o_vld / i_stall  | o_status, o_data, o_last
//
//  Push, pop, clear, count and walks on an empty stack use S_ONE; show walks
//  S_FETCH then S_WALK, remove and search add S_FIN, as the single read
//  port is registered. Only one request is in flight; o_stall is high until
//  its last result is registered. i_stall holds the walk while o_vld is set.
//  Synchronous active-low reset empties the stack; entry contents are kept.
module stack_with_search_remove
    import sws_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    output logic                     o_stall,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_vld,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state                   r_state, n_state;
    logic [CMD_W-1:0]         r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]            r_occ, n_occ;
    logic [AW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_wcnt, n_wcnt;
    logic                     r_pend, n_pend;
    logic [CW-1:0]            r_ppos, n_ppos;

    logic                     r_ovld;
    logic [STAT_W-1:0]        r_status;
    logic signed [DATA_W-1:0] r_data;
    logic                     r_last;

    logic                     emit;
    logic [STAT_W-1:0]        e_status;
    logic signed [DATA_W-1:0] e_data;
    logic                     e_last;

    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [AW-1:0]            raddr;
    logic signed [DATA_W-1:0] rdata;

    logic                     match;
    logic [CW-1:0]            pos;

    logic                     slot_free;
    logic                     empty;
    logic                     full;
    logic [AW-1:0]            occ_m1;
    logic [AW-1:0]            idx_next;
    logic                     at_end;

    sws_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sws_cmp #(
        .AW (AW),
        .CW (CW)
    ) u_cmp (
        .i_data  (rdata),
        .i_key   (r_val),
        .i_occ   (r_occ),
        .i_idx   (r_idx),
        .o_match (match),
        .o_pos   (pos)
    );

    assign slot_free = !r_ovld || !i_stall;
    assign empty     = (r_occ == '0);
    assign full      = (r_occ == CW'(DEPTH));
    assign occ_m1    = r_occ[AW-1:0] - AW'(1);
    assign idx_next  = (r_cmd == CMD_REMOVE) ? (r_idx + AW'(1)) : (r_idx - AW'(1));
    assign at_end    = (r_cmd == CMD_REMOVE) ? (r_idx == occ_m1) : (r_idx == '0);
    assign o_stall   = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_occ    = r_occ;
        n_idx    = r_idx;
        n_wcnt   = r_wcnt;
        n_pend   = r_pend;
        n_ppos   = r_ppos;
        emit     = 1'b0;
        e_status = ST_OK;
        e_data   = '0;
        e_last   = 1'b0;
        we       = 1'b0;
        waddr    = r_wcnt[AW-1:0];
        wdata    = rdata;
        raddr    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                raddr = occ_m1;
                if (i_vld) begin
                    n_cmd  = i_cmd;
                    n_val  = i_value;
                    n_pend = 1'b0;
                    n_wcnt = '0;
                    case (i_cmd)
                        CMD_SHOW, CMD_SEARCH: begin
                            n_idx   = occ_m1;
                            n_state = empty ? S_ONE : S_FETCH;
                        end
                        CMD_REMOVE: begin
                            n_idx   = '0;
                            n_state = empty ? S_ONE : S_FETCH;
                        end
                        CMD_PUSH, CMD_POP, CMD_CLEAR, CMD_COUNT: begin
                            n_state = S_ONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ONE: begin
                raddr = occ_m1;
                if (slot_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_PUSH: begin
                            if (full) begin
                                e_status = ST_FULL;
                            end else begin
                                we    = 1'b1;
                                waddr = r_occ[AW-1:0];
                                wdata = r_val;
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                e_status = ST_EMPTY;
                            end else begin
                                e_data = rdata;
                                n_occ  = r_occ - CW'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_occ = '0;
                        end
                        CMD_COUNT: begin
                            e_data = DATA_W'(r_occ);
                        end
                        CMD_SHOW, CMD_SEARCH: begin
                            e_status = ST_EMPTY;
                        end
                        default: begin
                            e_status = ST_OK;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                raddr   = r_idx;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (slot_free) begin
                    raddr = idx_next;
                    n_idx = idx_next;
                    case (r_cmd)
                        CMD_SHOW: begin
                            emit   = 1'b1;
                            e_data = rdata;
                            e_last = at_end;
                            if (at_end) begin
                                n_state = S_IDLE;
                            end
                        end
                        CMD_SEARCH: begin
                            if (match) begin
                                emit   = r_pend;
                                e_data = DATA_W'(r_ppos);
                                n_pend = 1'b1;
                                n_ppos = pos;
                            end
                            if (at_end) begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            if (!match) begin
                                we     = 1'b1;
                                n_wcnt = r_wcnt + CW'(1);
                            end
                            if (at_end) begin
                                n_state = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_SEARCH) begin
                        if (r_pend) begin
                            e_data = DATA_W'(r_ppos);
                        end else begin
                            e_status = ST_NOTFOUND;
                        end
                    end else begin
                        e_data = DATA_W'(r_occ - r_wcnt);
                        n_occ  = r_wcnt;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_wcnt <= n_wcnt;
        r_pend <= n_pend;
        r_ppos <= n_ppos;
        if (emit) begin
            r_status <= e_status;
            r_data   <= e_data;
            r_last   <= e_last;
        end
    end

    assign o_vld    = r_ovld;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_last   = r_last;

endmodule

// ----- rtl/core/sws_mem.sv -----
// Stack entry memory: one write port, one read port with registered read data.
module sws_mem
    import sws_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sws_cmp.sv -----
// Shared compare unit: entry match against the key and position from the top.
module sws_cmp
    import sws_pkg::*;
#(
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic signed [DATA_W-1:0] i_data,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic [CW-1:0]            i_occ,
    input  logic [AW-1:0]            i_idx,
    output logic                     o_match,
    output logic [CW-1:0]            o_pos
);

    assign o_match = (i_data == i_key);
    assign o_pos   = i_occ - CW'(i_idx);

endmodule

// ----- bench/tb_stack_with_search_remove.sv -----
// Self-checking testbench for the LIFO stack with show, count, remove and search commands.
module tb_stack_with_search_remove;
    import sws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int RANDOM_REQUESTS = 130;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_stack_reply;

    class t_stack_mirror;
        logic signed [DATA_W-1:0] entries [DEPTH];
        int level;
        t_stack_reply due_results [$];
        int mismatches;
        int results_seen;
        int full_refusals;
        int cmd_seen [8];

        function t_stack_reply reply(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] data);
            t_stack_reply r;
            r.status = status;
            r.data   = data;
            r.last   = 1'b0;
            return r;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
            t_stack_reply fresh [$];
            int kept;
            int hits;
            kept = 0;
            hits = 0;
            cmd_seen[cmd]++;
            case (cmd)
                CMD_PUSH: begin
                    if (level >= DEPTH) begin
                        fresh.push_back(reply(ST_FULL, '0));
                        full_refusals++;
                    end else begin
                        entries[level] = value;
                        level++;
                        fresh.push_back(reply(ST_OK, '0));
                    end
                end
                CMD_POP: begin
                    if (level == 0) begin
                        fresh.push_back(reply(ST_EMPTY, '0));
                    end else begin
                        level--;
                        fresh.push_back(reply(ST_OK, entries[level]));
                    end
                end
                CMD_CLEAR: begin
                    level = 0;
                    fresh.push_back(reply(ST_OK, '0));
                end
                CMD_SHOW: begin
                    if (level == 0) begin
                        fresh.push_back(reply(ST_EMPTY, '0));
                    end else begin
                        for (int i = level - 1; i >= 0; i--) begin
                            fresh.push_back(reply(ST_OK, entries[i]));
                        end
                    end
                end
                CMD_COUNT: fresh.push_back(reply(ST_OK, level));
                CMD_REMOVE: begin
                    for (int i = 0; i < level; i++) begin
                        if (entries[i] != value) begin
                            entries[kept] = entries[i];
                            kept++;
                        end
                    end
                    fresh.push_back(reply(ST_OK, level - kept));
                    level = kept;
                end
                CMD_SEARCH: begin
                    if (level == 0) begin
                        fresh.push_back(reply(ST_EMPTY, '0));
                    end else begin
                        for (int i = level - 1; i >= 0; i--) begin
                            if (entries[i] == value) begin
                                fresh.push_back(reply(ST_OK, level - i));
                                hits++;
                            end
                        end
                        if (hits == 0) fresh.push_back(reply(ST_NOTFOUND, '0));
                    end
                end
                default: ;
            endcase
            foreach (fresh[j]) begin
                fresh[j].last = (j == fresh.size() - 1);
                due_results.push_back(fresh[j]);
            end
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] data,
                                   logic last);
            t_stack_reply want;
            results_seen++;
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing pending: status %0d data %0d last %0d",
                         $time, status, data, last);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
                mismatches++;
            end
            if (data !== want.data) begin
                $display("%0t: data mismatch: expected %0d actual %0d",
                         $time, want.data, data);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch: expected %0d actual %0d",
                         $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_vld   = 1'b0;
    logic [CMD_W-1:0]         i_cmd   = CMD_PUSH;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_stall = 1'b0;
    logic                     steady  = 1'b0;
    logic                     o_stall;
    logic                     o_vld;
    logic [STAT_W-1:0]        o_status;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_last;

    t_stack_mirror board = new;
    logic signed [DATA_W-1:0] pool [4];
    int stall_left = 0;
    int random_sent = 0;

    stack_with_search_remove #(.DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_vld),
        .o_stall  (o_stall),
        .i_cmd    (i_cmd),
        .i_value  (i_value),
        .o_vld    (o_vld),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_data   (o_data),
        .o_last   (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (steady) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 99) < 20) begin
            i_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_vld && !i_stall) board.check_result(o_status, o_data, o_last);
    end

    function int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    function logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return CMD_PUSH;
        if (r < 47) return CMD_POP;
        if (r < 51) return CMD_CLEAR;
        if (r < 59) return CMD_SHOW;
        if (r < 66) return CMD_COUNT;
        if (r < 79) return CMD_REMOVE;
        if (r < 96) return CMD_SEARCH;
        return CMD_UNUSED;
    endfunction

    task automatic refresh_pool();
        foreach (pool[k]) begin
            case ($urandom_range(0, 7))
                0: pool[k] = VAL_MIN;
                1: pool[k] = VAL_MAX;
                2: pool[k] = '0;
                3: pool[k] = -1;
                default: pool[k] = $urandom;
            endcase
        end
    endtask

    task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
        int gap;
        i_vld   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        board.note_request(cmd, value);
        if (cmd != CMD_UNUSED) random_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            i_vld <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_vld <= 1'b0;
        while (board.due_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_POP, 32'sd7);
        send_request(CMD_SHOW, '0);
        send_request(CMD_SEARCH, 32'sd5);
        send_request(CMD_COUNT, '0);
        send_request(CMD_REMOVE, 32'sd5);
        send_request(CMD_UNUSED, -1);
        send_request(CMD_PUSH, VAL_MIN);
        send_request(CMD_PUSH, VAL_MAX);
        send_request(CMD_PUSH, '0);
        send_request(CMD_PUSH, -1);
        send_request(CMD_PUSH, VAL_MIN);
        send_request(CMD_SEARCH, VAL_MIN);
        send_request(CMD_SEARCH, 32'sd12345);
        send_request(CMD_SHOW, '0);
        send_request(CMD_COUNT, '0);
        send_request(CMD_REMOVE, VAL_MIN);
        send_request(CMD_POP, '0);
        send_request(CMD_SHOW, '0);
        send_request(CMD_CLEAR, VAL_MAX);
        send_request(CMD_COUNT, '0);
        send_request(CMD_POP, '0);
        wait_drained();

        random_sent = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            refresh_pool();
            steady <= ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) begin
                while (board.level < DEPTH) send_request(CMD_PUSH, pick_value());
                repeat ($urandom_range(1, 2)) send_request(CMD_PUSH, pick_value());
                send_request(CMD_SHOW, '0);
                send_request(CMD_SEARCH, pick_value());
                send_request(CMD_REMOVE, pick_value());
                send_request(CMD_POP, '0);
            end else begin
                repeat (12) send_request(pick_cmd(), pick_value());
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        steady <= 1'b0;
        wait_drained();
        repeat (25) @(posedge i_clk);

        while (board.due_results.size() != 0) begin
            void'(board.due_results.pop_front());
            $display("%0t: expected result never arrived", $time);
            board.mismatches++;
        end
        $display("covered push %0d (full %0d), pop %0d, clear %0d, show %0d, count %0d",
                 board.cmd_seen[CMD_PUSH], board.full_refusals, board.cmd_seen[CMD_POP],
                 board.cmd_seen[CMD_CLEAR], board.cmd_seen[CMD_SHOW], board.cmd_seen[CMD_COUNT]);
        $display("remove %0d, search %0d, unused code %0d; %0d results checked",
                 board.cmd_seen[CMD_REMOVE], board.cmd_seen[CMD_SEARCH],
                 board.cmd_seen[CMD_UNUSED], board.results_seen);
        if (board.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results pending", board.due_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
